@@ rtl/core/merge_sort_engine_defines.svh @@
// ----------------------------------------------------------------------------
// Merge sort engine assertion macros
// Shared wrappers for the concurrent checks of the merge sort engine.
// ----------------------------------------------------------------------------
`ifndef MERGE_SORT_ENGINE_DEFINES_SVH
`define MERGE_SORT_ENGINE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MSE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/mse_pkg.sv @@
// ----------------------------------------------------------------------------
// Merge sort engine package
// Payload types and the command and status groups between the blocks.
// ----------------------------------------------------------------------------
package mse_pkg;

   localparam int DATA_W = 32;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     last_item;
   } mse_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] sorted_value;
      logic                     last_result;
   } mse_rsp_type;

   // Datapath operations, at most one per cycle.
   typedef struct packed {
      logic load;
      logic sort_init;
      logic run_init;
      logic read;
      logic merge_step;
      logic emit_init;
      logic emit_read;
      logic emit_out;
   } mse_cmd_type;

   typedef struct packed {
      logic multi;
      logic run_last;
      logic pass_last;
      logic sort_last;
      logic emit_last;
   } mse_status_type;

endpackage

@@ rtl/core/mse_datapath.sv @@
// ----------------------------------------------------------------------------
// Merge sort engine datapath
// Ping-pong list buffers, run indices, comparator and result register.
// ----------------------------------------------------------------------------
module mse_datapath import mse_pkg::*; #(
   parameter int MAX_ITEMS = 64
) (
   input  logic           clock,
   input  logic           reset,
   input  mse_cmd_type    cmd,
   input  mse_req_type    req_data,
   output mse_status_type status,
   output logic           rsp_valid,
   output mse_rsp_type    rsp_data
);

   localparam int AW = $clog2(MAX_ITEMS);
   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);

   logic signed [DATA_W-1:0] mem0 [MAX_ITEMS];
   logic signed [DATA_W-1:0] mem1 [MAX_ITEMS];

   logic signed [DATA_W-1:0] rd0a_ff, rd0b_ff, rd1a_ff, rd1b_ff;
   logic [CW-1:0] count_ff, lo_ff, mid_ff, hi_ff, i_ff, j_ff, k_ff;
   logic [CW:0]   width_ff;
   logic          src_ff;
   logic          rsp_valid_ff;
   mse_rsp_type   rsp_ff;

   logic signed [DATA_W-1:0] op_a, op_b, wr_data;
   logic [AW-1:0] addr_a, addr_b;
   logic [CW+1:0] n_ext, mid_sum, hi_sum;
   logic [CW-1:0] mid_in, hi_in, k_next;
   logic          take_right;

   assign op_a    = src_ff ? rd1a_ff : rd0a_ff;
   assign op_b    = src_ff ? rd1b_ff : rd0b_ff;
   // On equal keys the right run goes first.
   assign take_right = (i_ff >= mid_ff) || ((j_ff < hi_ff) && !(op_a < op_b));
   assign wr_data = take_right ? op_b : op_a;
   assign k_next  = k_ff + CW'(1);

   assign n_ext   = {2'b00, count_ff};
   assign mid_sum = {2'b00, lo_ff} + {1'b0, width_ff};
   assign hi_sum  = {2'b00, lo_ff} + {width_ff, 1'b0};
   assign mid_in  = (mid_sum > n_ext) ? count_ff : mid_sum[CW-1:0];
   assign hi_in   = (hi_sum > n_ext) ? count_ff : hi_sum[CW-1:0];

   assign addr_a  = cmd.emit_read ? k_ff[AW-1:0] : i_ff[AW-1:0];
   assign addr_b  = j_ff[AW-1:0];

   assign status.multi     = (count_ff > CW'(1));
   assign status.run_last  = (k_next == hi_ff);
   assign status.pass_last = (hi_ff == count_ff);
   assign status.sort_last = ({width_ff, 1'b0} >= n_ext);
   assign status.emit_last = (k_next == count_ff);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (cmd.load && (count_ff < MAX_CNT)) begin
         mem0[count_ff[AW-1:0]] <= req_data.value;
      end else if (cmd.merge_step && src_ff) begin
         mem0[k_ff[AW-1:0]] <= wr_data;
      end
      if (cmd.merge_step && !src_ff) begin
         mem1[k_ff[AW-1:0]] <= wr_data;
      end
      if (cmd.read || cmd.emit_read) begin
         rd0a_ff <= mem0[addr_a];
         rd0b_ff <= mem0[addr_b];
         rd1a_ff <= mem1[addr_a];
         rd1b_ff <= mem1[addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sort_init) begin
         width_ff <= (CW+1)'(1);
         lo_ff    <= '0;
         src_ff   <= 1'b0;
      end
      if (cmd.run_init) begin
         mid_ff <= mid_in;
         hi_ff  <= hi_in;
         i_ff   <= lo_ff;
         j_ff   <= mid_in;
         k_ff   <= lo_ff;
      end
      if (cmd.merge_step) begin
         if (take_right) begin
            j_ff <= j_ff + CW'(1);
         end else begin
            i_ff <= i_ff + CW'(1);
         end
         k_ff <= k_next;
         if (status.run_last) begin
            if (status.pass_last) begin
               lo_ff    <= '0;
               width_ff <= {width_ff[CW-1:0], 1'b0};
               src_ff   <= ~src_ff;
            end else begin
               lo_ff <= hi_ff;
            end
         end
      end
      if (cmd.emit_init) begin
         k_ff <= '0;
      end
      if (cmd.emit_out) begin
         k_ff                <= k_next;
         rsp_ff.sorted_value <= op_a;
         rsp_ff.last_result  <= status.emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit_out;
         if (cmd.load && (count_ff < MAX_CNT)) begin
            count_ff <= count_ff + CW'(1);
         end else if (cmd.emit_out && status.emit_last) begin
            count_ff <= '0;
         end
      end
   end

endmodule

@@ rtl/core/mse_controller.sv @@
// ----------------------------------------------------------------------------
// Merge sort engine controller
// Sequences loading, the bottom-up merge passes and the emission of results.
// ----------------------------------------------------------------------------
module mse_controller import mse_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic           last_item,
   input  mse_status_type status,
   output mse_cmd_type    cmd,
   output logic           busy
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_RUN_INIT,
      ST_READ,
      ST_MERGE,
      ST_EMIT_INIT,
      ST_EMIT_READ,
      ST_EMIT_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;

   assign busy = busy_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (last_item) begin
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            cmd.sort_init = 1'b1;
            state_in      = status.multi ? ST_RUN_INIT : ST_EMIT_INIT;
         end
         ST_RUN_INIT: begin
            cmd.run_init = 1'b1;
            state_in     = ST_READ;
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_MERGE;
         end
         ST_MERGE: begin
            cmd.merge_step = 1'b1;
            if (!status.run_last) begin
               state_in = ST_READ;
            end else if (status.pass_last && status.sort_last) begin
               state_in = ST_EMIT_INIT;
            end else begin
               state_in = ST_RUN_INIT;
            end
         end
         ST_EMIT_INIT: begin
            cmd.emit_init = 1'b1;
            state_in      = ST_EMIT_READ;
         end
         ST_EMIT_READ: begin
            cmd.emit_read = 1'b1;
            state_in      = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            cmd.emit_out = 1'b1;
            state_in     = status.emit_last ? ST_IDLE : ST_EMIT_READ;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != ST_IDLE);
      end
   end

endmodule

@@ rtl/core/merge_sort_engine.sv @@
// ----------------------------------------------------------------------------
// Merge sort engine
// Collects a list of signed words and returns it in ascending order.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake          Payload        Direction
//   request   start / busy       req_data       in
//   response  rsp_valid strobe   rsp_data       out
//
// After the transaction that carries last_item, the engine sorts with
// ceil(log2 n) merge passes; a registered buffer read comes ahead of every
// merge step and of every response, so responses never come back to back.
// busy stays high from the final request to the last response. Reset is
// synchronous and clears the control state; the list buffers are not
// cleared. The receiver cannot stall.
//
`include "merge_sort_engine_defines.svh"

module merge_sort_engine import mse_pkg::*; #(
   parameter int MAX_ITEMS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  mse_req_type req_data,
   output logic        rsp_valid,
   output mse_rsp_type rsp_data
);

   // The controller and the datapath talk only through these two groups.
   mse_cmd_type    cmd;
   mse_status_type status;

   // The controller accepts a request transaction only while idle, so busy
   // doubles as the request handshake and as the sorting indicator.
   mse_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .last_item (req_data.last_item),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy)
   );

   // The datapath holds both list buffers; passes alternate between them, so
   // no copy-back is needed and the final pass leaves the sorted list in
   // whichever buffer it wrote.
   mse_datapath #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // Responses only arise from a sort that was in progress in the cycle before.
   `MSE_ASSERT_SAME(a_rsp_after_busy, clock, reset, rsp_valid, $past(busy), "response while idle")

   // The final response finds the engine ready for the next list.
   `MSE_ASSERT_SAME(a_last_frees, clock, reset, rsp_valid && rsp_data.last_result, !busy, "still busy")

   // Emission reads the buffer between responses, so strobes never abut.
   `MSE_ASSERT_NEXT(a_rsp_spacing, clock, reset, rsp_valid, !rsp_valid, "responses abut")

   // The controller issues at most one datapath operation per cycle.
   `MSE_ASSERT_SAME(a_cmd_onehot, clock, reset, 1'b1, $onehot0(cmd), "overlapping commands")

endmodule

@@ sim/tb_merge_sort_engine.sv @@
// ----------------------------------------------------------------------------
// Merge sort engine testbench
// Sends lists of signed words into the engine and checks every sorted word
// that comes back against a bottom-up merge sort kept inside the bench.
// ----------------------------------------------------------------------------
module tb_merge_sort_engine;
   import mse_pkg::*;

   localparam int MAX_ITEMS       = 64;
   // The slowest quiet stretch is the sort of a full list, and this limit
   // leaves a wide margin over it before the run is declared hung.
   localparam int WATCHDOG_LIMIT  = 8000;
   // Cycles to keep watching after the last expected word, to catch strays.
   localparam int SETTLE_CYCLES   = 300;
   localparam int RANDOM_ITEMS    = 160;

   // One request transaction waiting to be sent, with the pacing that goes
   // with it: how often the sender idles and whether it must first wait for
   // the previous list to be returned in full.
   typedef struct {
      mse_req_type req;
      int          idle_pct;
      bit          drain;
   } list_item_type;

   logic        clock    = 1'b0;
   logic        reset    = 1'b1;
   logic        start    = 1'b0;
   mse_req_type req_data = '0;
   logic        busy;
   logic        rsp_valid;
   mse_rsp_type rsp_data;

   list_item_type list_items[$];
   mse_rsp_type   due_words[$];

   // Mirror of the engine's list store, written as transactions are accepted.
   logic signed [DATA_W-1:0] stored_words  [MAX_ITEMS];
   logic signed [DATA_W-1:0] scratch_words [MAX_ITEMS];
   int                       stored_count = 0;

   // Number of sorted words still owed, updated with nonblocking assignments
   // so that the driver and the end of the run see a settled value.
   int results_due  = 0;
   int fail_count   = 0;
   int quiet_cycles = 0;

   merge_sort_engine #(
      .MAX_ITEMS (MAX_ITEMS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   // Takes one accepted word into the mirror. When the word closes the list,
   // the stored words are sorted bottom-up and the sorted list is queued as
   // the words the engine owes. Returns how many words were queued.
   function automatic int absorb_word(input mse_req_type item);
      int width, lo, mid, hi, i, j, k, n;
      mse_rsp_type word;
      // Once the store is full, further words are dropped but a closing flag
      // on a dropped word still ends the list.
      if (stored_count < MAX_ITEMS) begin
         stored_words[stored_count] = item.value;
         stored_count++;
      end
      if (!item.last_item) return 0;
      n = stored_count;
      for (width = 1; width < n; width *= 2) begin
         for (lo = 0; lo < n; lo += 2 * width) begin
            mid = (lo + width > n) ? n : lo + width;
            hi  = (lo + 2 * width > n) ? n : lo + 2 * width;
            if (mid < hi) begin
               i = lo;
               j = mid;
               for (k = lo; k < hi; k++) begin
                  // On equal keys the right-hand run gives up its word first.
                  if (j >= hi || (i < mid && stored_words[i] < stored_words[j])) begin
                     scratch_words[k] = stored_words[i];
                     i++;
                  end else begin
                     scratch_words[k] = stored_words[j];
                     j++;
                  end
               end
               for (k = lo; k < hi; k++) stored_words[k] = scratch_words[k];
            end
         end
      end
      for (k = 0; k < n; k++) begin
         word.sorted_value = stored_words[k];
         word.last_result  = (k == n - 1);
         due_words.push_back(word);
      end
      stored_count = 0;
      return n;
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_word();
      int roll;
      roll = $urandom_range(99);
      if (roll < 60) return $urandom;
      // Small values give plenty of equal keys.
      if (roll < 85) return $signed($urandom_range(8)) - 4;
      case ($urandom_range(4))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return 32'sd0;
         3: return -32'sd1;
         default: return 32'sd1;
      endcase
   endfunction

   task automatic queue_word(input logic signed [DATA_W-1:0] value, input bit last,
                             input bit drain);
      list_item_type entry;
      entry.req.value     = value;
      entry.req.last_item = last;
      entry.idle_pct      = 0;
      entry.drain         = drain;
      list_items.push_back(entry);
   endtask

   // Queues a list of random words; the closing flag goes on word number
   // length, so a length above the capacity ends on a word that is dropped.
   task automatic queue_random_list(input int length, input bit drain);
      for (int idx = 0; idx < length; idx++) begin
         queue_word(pick_word(), idx == length - 1, drain && idx == 0);
      end
   endtask

   // Driver: offers the head of the queue. A transaction is held until the
   // engine takes it; a new one is only chosen once the previous is gone.
   always @(posedge clock) begin
      logic        next_start;
      mse_req_type next_data;
      bit          taken;
      if (reset) begin
         start    <= 1'b0;
         req_data <= '0;
      end else begin
         taken      = start && !busy;
         next_start = start;
         next_data  = req_data;
         if (taken || !start) begin
            next_start = 1'b0;
            if (list_items.size() != 0) begin
               // A draining list waits for the engine to return every owed
               // word; the edge of an acceptance never counts as drained, as
               // its results are not yet on the books.
               if (list_items[0].drain && (taken || busy || results_due != 0)) begin
                  next_start = 1'b0;
               end else if ($urandom_range(99) < list_items[0].idle_pct) begin
                  next_start = 1'b0;
               end else begin
                  next_start = 1'b1;
                  next_data  = list_items[0].req;
                  list_items.pop_front();
               end
            end
         end
         start    <= next_start;
         req_data <= next_data;
      end
   end

   // Monitor: checks each response transaction against the oldest owed word
   // and feeds each accepted request transaction to the mirror.
   always @(posedge clock) begin
      int          taken_words;
      int          new_words;
      mse_rsp_type want;
      if (reset) begin
         results_due <= 0;
      end else begin
         taken_words = 0;
         new_words   = 0;
         if (rsp_valid) begin
            if (due_words.size() == 0) begin
               $error("unexpected response: sorted_value %0d last_result %0b",
                      rsp_data.sorted_value, rsp_data.last_result);
               fail_count++;
            end else begin
               want = due_words.pop_front();
               taken_words = 1;
               if (rsp_data.sorted_value !== want.sorted_value) begin
                  $error("sorted_value: expected %0d, actual %0d",
                         want.sorted_value, rsp_data.sorted_value);
                  fail_count++;
               end
               if (rsp_data.last_result !== want.last_result) begin
                  $error("last_result: expected %0b, actual %0b",
                         want.last_result, rsp_data.last_result);
                  fail_count++;
               end
            end
         end
         if (start && !busy) new_words = absorb_word(req_data);
         results_due <= results_due + new_words - taken_words;
      end
   end

   // Watchdog: a hung engine shows up as a long run of cycles with no
   // transaction on either channel.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int random_words;
      int list_len;
      int total;
      bit full_done;
      bit overflow_done;

      // Directed lists: single words at both extremes, the extremes mixed,
      // equal keys, reversed and already sorted lists, and alternating duplicates.
      queue_word(32'sh7fff_ffff, 1'b1, 1'b0);
      queue_word(32'sh8000_0000, 1'b1, 1'b0);
      queue_word(32'sh7fff_ffff, 1'b0, 1'b0);
      queue_word(32'sh8000_0000, 1'b0, 1'b0);
      queue_word(32'sd0,         1'b0, 1'b0);
      queue_word(-32'sd1,        1'b0, 1'b0);
      queue_word(32'sd1,         1'b1, 1'b0);
      queue_word(32'sd7, 1'b0, 1'b0);
      queue_word(32'sd7, 1'b0, 1'b0);
      queue_word(32'sd7, 1'b1, 1'b0);
      queue_word(32'sd5,  1'b0, 1'b0);
      queue_word(-32'sd5, 1'b1, 1'b0);
      queue_word(-32'sd3, 1'b0, 1'b0);
      queue_word(-32'sd2, 1'b0, 1'b0);
      queue_word(-32'sd1, 1'b0, 1'b0);
      queue_word(32'sd0,  1'b1, 1'b0);
      queue_word(32'sd1,         1'b0, 1'b0);
      queue_word(32'sh8000_0000, 1'b0, 1'b0);
      queue_word(32'sd1,         1'b0, 1'b0);
      queue_word(32'sh8000_0000, 1'b1, 1'b0);

      // Random lists, mostly short. One list fills the store exactly and one
      // overruns it, so that its closing word is itself dropped.
      random_words  = 0;
      full_done     = 1'b0;
      overflow_done = 1'b0;
      while (random_words < RANDOM_ITEMS) begin
         if (!full_done && random_words >= 40) begin
            queue_random_list(MAX_ITEMS, 1'b0);
            random_words += MAX_ITEMS;
            full_done = 1'b1;
         end else if (!overflow_done && random_words >= 110) begin
            list_len = MAX_ITEMS + $urandom_range(3, 1);
            queue_random_list(list_len, 1'b1);
            random_words += list_len;
            overflow_done = 1'b1;
         end else begin
            list_len = ($urandom_range(99) < 85) ? $urandom_range(8, 1)
                                                 : $urandom_range(20, 9);
            // The first random list always waits for the directed ones.
            queue_random_list(list_len, random_words == 0 || $urandom_range(3) == 0);
            random_words += list_len;
         end
      end

      // Pacing by position: the sender idles often at first, then very often,
      // then not at all.
      total = list_items.size();
      for (int idx = 0; idx < total; idx++) begin
         if (idx < total / 3)          list_items[idx].idle_pct = 26;
         else if (idx < 2 * total / 3) list_items[idx].idle_pct = 68;
         else                          list_items[idx].idle_pct = 0;
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Values are looked at on the falling edge, after every clocked block
      // has settled.
      do @(negedge clock);
      while (list_items.size() != 0 || start || results_due != 0 || busy);
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (due_words.size() != 0) begin
         $error("%0d sorted words never arrived", due_words.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/mse_pkg.sv
rtl/core/mse_datapath.sv
rtl/core/mse_controller.sv
rtl/core/merge_sort_engine.sv
sim/tb_merge_sort_engine.sv
